>>> sv/bilinear_texture_shade_macros.svh
// assertion macros for the bilinear texture shade block
// used by the top level only; needs clk_i and rst_ni in scope
`ifndef BILINEAR_TEXTURE_SHADE_MACROS_SVH
`define BILINEAR_TEXTURE_SHADE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define BTS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("bilinear_texture_shade assertion failed");
`define BTS_ASSERT_AFTER6(lbl, cause, effect) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cause) |-> ##6 (effect)) \
    else $error("bilinear_texture_shade latency check failed");
`else
`define BTS_ASSERT(lbl, prop)
`define BTS_ASSERT_AFTER6(lbl, cause, effect)
`endif
`endif

>>> sv/bts_pkg.sv
// shared types and constants of the bilinear texture shade block
// no dependencies
package bts_pkg;

  typedef enum logic {
    REQ_LOAD   = 1'b0,
    REQ_SAMPLE = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    REG_TEX_WIDTH   = 2'd0,
    REG_TEX_HEIGHT  = 2'd1,
    REG_TEX_PRESENT = 2'd2
  } reg_e;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // flat grey of 0.72 in q16, scaled to the accumulator format
  localparam logic [15:0] GREY_Q16 = 16'd47186;
  localparam logic [42:0] GREY_ACC = 43'(64'd47186 * 64'd255 * 64'd65536);

endpackage

>>> sv/bts_front.sv
// front end: config registers, request classification, sample position setup
// depends on bts_pkg
module bts_front #(
  parameter int MAX_TEX_DIM     = 256,
  parameter int COORD_FRAC_BITS = 16,
  parameter int EW              = 128
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [8:0]    cfg_wdata_i,
  input  logic          req_type_i,
  input  logic [7:0]    texel_x_i,
  input  logic [7:0]    texel_y_i,
  input  logic [7:0]    load_red_i,
  input  logic [7:0]    load_green_i,
  input  logic [7:0]    load_blue_i,
  input  logic [23:0]   coord_u_i,
  input  logic [23:0]   coord_v_i,
  input  logic [11:0]   shade_factor_i,
  output logic [EW-1:0] entry_o
);

  localparam int F    = COORD_FRAC_BITS;
  localparam int DW   = $clog2(MAX_TEX_DIM + 1);
  localparam int BW   = DW + 1;
  localparam int PW   = F + 1 + DW + 1;
  localparam int SH_R = (F >= 16) ? F - 16 : 0;
  localparam int SH_L = (F >= 16) ? 0 : 16 - F;

  typedef struct packed {
    logic                 is_sample;
    logic                 present;
    logic signed [BW-1:0] x0;
    logic signed [BW-1:0] y0;
    logic [15:0]          dx;
    logic [15:0]          dy;
    logic [DW-1:0]        w;
    logic [DW-1:0]        h;
    logic [7:0]           lx;
    logic [7:0]           ly;
    logic [7:0]           lr;
    logic [7:0]           lg;
    logic [7:0]           lb;
    logic [11:0]          shade;
  } entry_t;

  logic [8:0] width_q, height_q;
  logic       present_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= 9'd1;
      height_q  <= 9'd1;
      present_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bts_pkg::REG_TEX_WIDTH:   width_q   <= cfg_wdata_i;
        bts_pkg::REG_TEX_HEIGHT:  height_q  <= cfg_wdata_i;
        bts_pkg::REG_TEX_PRESENT: present_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  function automatic logic [DW-1:0] eff_dim(input logic [8:0] d);
    logic [DW-1:0] r;
    if (d == 9'd0) r = DW'(1);
    else if (32'(d) > 32'(MAX_TEX_DIM)) r = DW'(MAX_TEX_DIM);
    else r = DW'(d);
    return r;
  endfunction

  logic [DW-1:0] w_eff, h_eff;
  logic [F:0]    uf, vf;
  logic [PW-1:0] pos_u, pos_v;
  entry_t        e;

  assign w_eff = eff_dim(width_q);
  assign h_eff = eff_dim(height_q);
  assign uf    = {1'b0, coord_u_i[F-1:0]};
  // v flips: an integer v becomes exactly one
  assign vf    = (F+1)'(1) << F;
  logic [F:0] vflip;
  assign vflip = vf - {1'b0, coord_v_i[F-1:0]};

  assign pos_u = PW'(uf) * PW'(w_eff) + PW'(1 << (F - 1)) * PW'(1);
  assign pos_v = PW'(vflip) * PW'(h_eff) + PW'(1 << (F - 1));

  always_comb begin
    e           = '0;
    e.is_sample = req_type_i;
    e.present   = present_q;
    e.x0        = $signed({1'b0, DW'(pos_u >> F)}) - BW'(1);
    e.y0        = $signed({1'b0, DW'(pos_v >> F)}) - BW'(1);
    e.dx        = 16'((32'(pos_u[F-1:0]) >> SH_R) << SH_L);
    e.dy        = 16'((32'(pos_v[F-1:0]) >> SH_R) << SH_L);
    e.w         = w_eff;
    e.h         = h_eff;
    e.lx        = texel_x_i;
    e.ly        = texel_y_i;
    e.lr        = load_red_i;
    e.lg        = load_green_i;
    e.lb        = load_blue_i;
    e.shade     = shade_factor_i;
  end

  assign entry_o = EW'(e);

endmodule

>>> sv/bts_queue.sv
// two-entry queue between front and back
// depends on bts_pkg
module bts_queue #(
  parameter int EW = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic [EW-1:0]      data_i,
  input  logic               pop_i,
  output logic [EW-1:0]      data_o,
  output bts_pkg::q_status_t status_o
);

  logic [EW-1:0] mem_q [2];
  logic          wr_q, rd_q;
  logic [1:0]    cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  assign data_o         = mem_q[rd_q];
  assign status_o.full  = (cnt_q == 2'd2);
  assign status_o.empty = (cnt_q == 2'd0);

endmodule

>>> sv/bts_back.sv
// back end: banked texel store, bilinear blend, shade and saturate
// depends on bts_pkg
module bts_back #(
  parameter int MAX_TEX_DIM     = 256,
  parameter int COORD_FRAC_BITS = 16,
  parameter int EW              = 128
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [EW-1:0] entry_i,
  output logic          done_o,
  output bts_pkg::rgb_t rgb_o
);

  localparam int DW    = $clog2(MAX_TEX_DIM + 1);
  localparam int BW    = DW + 1;
  localparam int IW    = $clog2(MAX_TEX_DIM);
  localparam int HALF  = (MAX_TEX_DIM + 1) / 2;
  localparam int DEPTH = HALF * HALF;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef struct packed {
    logic                 is_sample;
    logic                 present;
    logic signed [BW-1:0] x0;
    logic signed [BW-1:0] y0;
    logic [15:0]          dx;
    logic [15:0]          dy;
    logic [DW-1:0]        w;
    logic [DW-1:0]        h;
    logic [7:0]           lx;
    logic [7:0]           ly;
    logic [7:0]           lr;
    logic [7:0]           lg;
    logic [7:0]           lb;
    logic [11:0]          shade;
  } entry_t;

  entry_t e;
  assign e = entry_t'(entry_i);

  function automatic logic [IW-1:0] clamp_idx(input logic signed [BW:0] i,
                                              input logic [DW-1:0] dim);
    logic [IW-1:0] r;
    if (i < 0) r = '0;
    else if (i >= $signed({2'b00, dim})) r = IW'(dim - DW'(1));
    else r = IW'(i);
    return r;
  endfunction

  // stage a: clamp, bank addressing, weights
  logic [IW-1:0] sx [2];
  logic [IW-1:0] sy [2];
  logic [16:0]   wx [2];
  logic [16:0]   wy [2];

  always_comb begin
    sx[0] = clamp_idx({e.x0[BW-1], e.x0}, e.w);
    sx[1] = clamp_idx({e.x0[BW-1], e.x0} + (BW+1)'(1), e.w);
    sy[0] = clamp_idx({e.y0[BW-1], e.y0}, e.h);
    sy[1] = clamp_idx({e.y0[BW-1], e.y0} + (BW+1)'(1), e.h);
    wx[0] = 17'h10000 - {1'b0, e.dx};
    wx[1] = {1'b0, e.dx};
    wy[0] = 17'h10000 - {1'b0, e.dy};
    wy[1] = {1'b0, e.dy};
  end

  logic        load_ok;
  logic        do_read;
  logic [AW-1:0] laddr;
  assign load_ok = valid_i && !e.is_sample &&
                   (32'(e.lx) < 32'(MAX_TEX_DIM)) && (32'(e.ly) < 32'(MAX_TEX_DIM));
  assign do_read = valid_i && e.is_sample && e.present;
  assign laddr   = AW'(32'(e.ly >> 1) * 32'(HALF) + 32'(e.lx >> 1));

  logic [23:0] rd_q [4];

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [23:0]   mem [DEPTH];
    logic [IW-1:0] xsel, ysel;
    logic [AW-1:0] addr;
    logic          we;
    assign xsel = (sx[0][0] == b[0]) ? sx[0] : sx[1];
    assign ysel = (sy[0][0] == b[1]) ? sy[0] : sy[1];
    assign we   = load_ok && (e.lx[0] == b[0]) && (e.ly[0] == b[1]);
    assign addr = we ? laddr
                     : AW'(32'(ysel >> 1) * 32'(HALF) + 32'(xsel >> 1));
    always_ff @(posedge clk_i) begin
      if (we) mem[addr] <= {e.lr, e.lg, e.lb};
      if (do_read) rd_q[b] <= mem[addr];
    end
  end

  logic        a_vld_q, a_pres_q;
  logic [32:0] wt_q [4];
  logic [1:0]  tsel_q [4];
  logic [11:0] a_shade_q;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) begin
      wt_q[k]   <= 33'(wx[k % 2] * wy[k / 2]);
      tsel_q[k] <= {sy[k / 2][0], sx[k % 2][0]};
    end
    a_pres_q  <= e.present;
    a_shade_q <= e.shade;
  end

  // stage b: weight times texel channel
  logic        b_vld_q, b_pres_q;
  logic [40:0] prod_q [4][3];
  logic [11:0] b_shade_q;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) begin
      for (int c = 0; c < 3; c++) begin
        prod_q[k][c] <= 41'(wt_q[k] * rd_q[tsel_q[k]][23 - 8*c -: 8]);
      end
    end
    b_pres_q  <= a_pres_q;
    b_shade_q <= a_shade_q;
  end

  // stage c: sum of the four taps, or flat grey
  logic        c_vld_q;
  logic [42:0] acc_q [3];
  logic [11:0] c_shade_q;

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      if (b_pres_q) begin
        acc_q[c] <= 43'(prod_q[0][c]) + 43'(prod_q[1][c]) +
                    43'(prod_q[2][c]) + 43'(prod_q[3][c]);
      end else begin
        acc_q[c] <= bts_pkg::GREY_ACC;
      end
    end
    c_shade_q <= b_shade_q;
  end

  // stage d: shade multiply
  logic        d_vld_q;
  logic [54:0] sh_q [3];

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) sh_q[c] <= 55'(acc_q[c] * c_shade_q);
  end

  // stage e: scale and saturate
  logic [12:0]   r13 [3];
  logic [7:0]    sat [3];
  bts_pkg::rgb_t out_q;
  logic          out_vld_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      r13[c] = sh_q[c][54:42];
      sat[c] = (r13[c] > 13'd255) ? 8'hff : r13[c][7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    out_q.red   <= sat[0];
    out_q.green <= sat[1];
    out_q.blue  <= sat[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q   <= 1'b0;
      b_vld_q   <= 1'b0;
      c_vld_q   <= 1'b0;
      d_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      a_vld_q   <= valid_i && e.is_sample;
      b_vld_q   <= a_vld_q;
      c_vld_q   <= b_vld_q;
      d_vld_q   <= c_vld_q;
      out_vld_q <= d_vld_q;
    end
  end

  assign done_o = out_vld_q;
  assign rgb_o  = out_q;

endmodule

>>> sv/bilinear_texture_shade.sv
// top level of the bilinear texture shade block
// depends on bts_pkg, bts_front, bts_queue, bts_back and the macro header
//
// channel  | handshake          | payload
// config   | cfg_we_i           | cfg_idx_i, cfg_wdata_i
// request  | start_i, busy_o    | req_type_i .. shade_factor_i
// result   | done_o (strobe)    | out_red_o, out_green_o, out_blue_o
//
// one item per clock while not busy; samples go via the queue to stages a-e
// the four texel reads go to four parity banks, one single-port read each
// loads write one bank in the back end and give no result
// the back end never stalls, so the two-entry queue stays near empty
// reset clears control only; the texel store is undefined until loaded
`include "bilinear_texture_shade_macros.svh"
module bilinear_texture_shade #(
  parameter int MAX_TEX_DIM     = 256,
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [8:0]  cfg_wdata_i,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        req_type_i,
  input  logic [7:0]  texel_x_i,
  input  logic [7:0]  texel_y_i,
  input  logic [7:0]  load_red_i,
  input  logic [7:0]  load_green_i,
  input  logic [7:0]  load_blue_i,
  input  logic [23:0] coord_u_i,
  input  logic [23:0] coord_v_i,
  input  logic [11:0] shade_factor_i,
  output logic        done_o,
  output logic [7:0]  out_red_o,
  output logic [7:0]  out_green_o,
  output logic [7:0]  out_blue_o
);

  localparam int DW = $clog2(MAX_TEX_DIM + 1);
  localparam int BW = DW + 1;
  localparam int EW = 86 + 2 * BW + 2 * DW;

  logic               accept;
  logic [EW-1:0]      f_entry, q_entry;
  bts_pkg::q_status_t q_stat;
  bts_pkg::rgb_t      rgb;

  assign accept = start_i && !busy_o;
  assign busy_o = q_stat.full;

  bts_front #(
    .MAX_TEX_DIM(MAX_TEX_DIM), .COORD_FRAC_BITS(COORD_FRAC_BITS), .EW(EW)
  ) u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .req_type_i, .texel_x_i, .texel_y_i, .load_red_i, .load_green_i,
    .load_blue_i, .coord_u_i, .coord_v_i, .shade_factor_i,
    .entry_o(f_entry)
  );

  bts_queue #(.EW(EW)) u_queue (
    .clk_i, .rst_ni,
    .push_i  (accept),
    .data_i  (f_entry),
    .pop_i   (!q_stat.empty),
    .data_o  (q_entry),
    .status_o(q_stat)
  );

  bts_back #(
    .MAX_TEX_DIM(MAX_TEX_DIM), .COORD_FRAC_BITS(COORD_FRAC_BITS), .EW(EW)
  ) u_back (
    .clk_i, .rst_ni,
    .valid_i(!q_stat.empty),
    .entry_i(q_entry),
    .done_o,
    .rgb_o  (rgb)
  );

  assign out_red_o   = rgb.red;
  assign out_green_o = rgb.green;
  assign out_blue_o  = rgb.blue;

  `BTS_ASSERT(a_queue_never_full, !q_stat.full)
  `BTS_ASSERT_AFTER6(a_sample_result, accept && req_type_i, done_o)
  `BTS_ASSERT_AFTER6(a_load_silent, accept && !req_type_i, !done_o)

endmodule
